>>> rtl/core/u2u_pkg.sv
`timescale 1ns / 1ps

package u2u_pkg;

	localparam int unsigned CFG_IDX_BITS = 1;
	localparam int unsigned CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_ONLY = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_UNITS = 1'd1;

	localparam logic [15:0] MAX_UNITS_RESET = 16'hffff;

	// lead and continuation byte classes
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] CONT_MASK = 8'hc0;
	localparam logic [7:0] CONT_CODE = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'he0;
	localparam logic [7:0] LEAD2_CODE = 8'hc0;
	localparam logic [7:0] LEAD3_MASK = 8'hf0;
	localparam logic [7:0] LEAD3_CODE = 8'he0;
	localparam logic [7:0] TERM_BYTE = 8'h00;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_LIMIT = 2'd1,
		STATUS_INVALID = 2'd2,
		STATUS_DISCARD = 2'd3
	} u2u_status_t;

	typedef struct packed {
		logic [1:0] pending;
		logic [15:0] partial;
		logic discarding;
	} u2u_state_t;

	typedef struct packed {
		logic unit_valid;
		logic [15:0] code_unit;
		logic done_res;
		u2u_status_t status;
		logic [15:0] unit_count;
	} u2u_result_t;

endpackage

>>> rtl/core/u2u_if.sv
`timescale 1ns / 1ps

interface u2u_byte_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface u2u_unit_if;
	logic valid;
	logic ready;
	logic unit_valid;
	logic [15:0] code_unit;
	logic done_res;
	logic [1:0] status;
	logic [15:0] unit_count;

	modport source (output valid, output unit_valid, output code_unit, output done_res,
		output status, output unit_count, input ready);
	modport sink (input valid, input unit_valid, input code_unit, input done_res,
		input status, input unit_count, output ready);
endinterface

>>> rtl/core/u2u_step.sv
`timescale 1ns / 1ps

module u2u_step import u2u_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input logic [7:0] data_byte,
	input u2u_state_t st,
	input logic [COUNT_BITS-1:0] count,
	input logic count_only,
	input logic [15:0] max_units,
	output u2u_state_t st_next,
	output logic [COUNT_BITS-1:0] count_next,
	output u2u_result_t res
);

	localparam int unsigned CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

	logic writing;
	logic at_limit;
	logic zero_limit;
	logic [COUNT_BITS-1:0] count_bump;
	logic [COUNT_BITS-1:0] cnt_out;
	logic [CW-1:0] cnt_ext;

	assign writing = !count_only;
	assign at_limit = CW'(count) >= CW'(max_units);
	assign zero_limit = writing && (max_units == 16'd0) && (st.pending == 2'd0)
		&& (count == '0);
	// saturating increment
	assign count_bump = (&count) ? count : COUNT_BITS'(count + 1'b1);

	always_comb begin
		st_next = st;
		count_next = count;
		cnt_out = count;
		res = '0;
		res.status = STATUS_OK;

		if (st.discarding) begin
			res.status = STATUS_DISCARD;
			if (data_byte == TERM_BYTE) begin
				st_next = '0;
				count_next = '0;
			end
		end else if (zero_limit) begin
			res.status = STATUS_LIMIT;
			res.done_res = 1'b1;
			cnt_out = '0;
			if (data_byte != TERM_BYTE) begin
				st_next.discarding = 1'b1;
			end
		end else if (data_byte == TERM_BYTE) begin
			res.done_res = 1'b1;
			if (st.pending != 2'd0) begin
				res.status = STATUS_INVALID;
			end else if (writing && !at_limit) begin
				// terminating zero unit
				res.unit_valid = 1'b1;
			end
			st_next = '0;
			count_next = '0;
		end else if (st.pending != 2'd0) begin
			if ((data_byte & CONT_MASK) != CONT_CODE) begin
				res.status = STATUS_INVALID;
				res.done_res = 1'b1;
				st_next.discarding = 1'b1;
			end else if (st.pending >= 2'd2) begin
				st_next.partial = st.partial | {4'd0, data_byte[5:0], 6'd0};
				st_next.pending = 2'd1;
			end else begin
				res.unit_valid = writing;
				res.code_unit = writing ? (st.partial | {10'd0, data_byte[5:0]}) : 16'd0;
				st_next.pending = 2'd0;
			end
		end else if (writing && at_limit) begin
			res.status = STATUS_LIMIT;
			res.done_res = 1'b1;
			st_next.discarding = 1'b1;
		end else begin
			if ((data_byte & ASCII_MASK) == 8'd0) begin
				count_next = count_bump;
				res.unit_valid = writing;
				res.code_unit = writing ? {9'd0, data_byte[6:0]} : 16'd0;
			end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
				st_next.partial = {5'd0, data_byte[4:0], 6'd0};
				st_next.pending = 2'd1;
				count_next = count_bump;
			end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
				st_next.partial = {data_byte[3:0], 12'd0};
				st_next.pending = 2'd2;
				count_next = count_bump;
			end else begin
				// four-byte or longer lead, or stray continuation
				res.status = STATUS_INVALID;
				res.done_res = 1'b1;
				st_next.discarding = 1'b1;
			end
			cnt_out = count_next;
		end

		cnt_ext = CW'(cnt_out);
		res.unit_count = cnt_ext[15:0];
	end

endmodule

>>> rtl/core/utf8_to_utf16_decoder.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 decoder for the Basic Multilingual Plane.
// byte_ch carries one byte of a zero-terminated UTF-8 string per transfer;
// unit_ch returns exactly one result per byte: an optional code unit, a done
// flag, a status code and the running unit count of the current string.
// Configuration (count_only, max_units) is written through cfg_we, cfg_index
// and cfg_data while the block is idle; each write takes effect at once.
// A byte accepted into the input register is decoded from there and its result
// is registered in the output register, shown on unit_ch from then on.
// Throughput: one byte per cycle while unit_ch does not stall; the decode of one
// byte against the string state and the count-against-limit compare sit between the two registers.
// A byte may be taken while an earlier result still waits on unit_ch.
// When the receiver stalls, the result register holds, the input register
// fills and byte_ch.ready drops until unit_ch.ready returns.
// Reset clears the string state, empties both registers, sets count_only
// to 0 and max_units to 65535.
module utf8_to_utf16_decoder import u2u_pkg::*; #(
	parameter int unsigned COUNT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_index,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	u2u_byte_if.sink byte_ch,
	u2u_unit_if.source unit_ch
);

	logic count_only_q;
	logic [15:0] max_units_q;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic valid_s2;
	u2u_result_t res_s2;

	u2u_state_t state_q;
	u2u_state_t state_next;
	logic [COUNT_BITS-1:0] count_q;
	logic [COUNT_BITS-1:0] count_next;
	u2u_result_t res;

	logic advance;
	logic take;
	logic byte_xfer;

	assign advance = !valid_s2 || unit_ch.ready;
	assign take = valid_s1 && advance;
	assign byte_ch.ready = !valid_s1 || advance;
	assign byte_xfer = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_only_q <= 1'b0;
			max_units_q <= MAX_UNITS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT_ONLY: count_only_q <= cfg_data[0];
				CFG_MAX_UNITS: max_units_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_xfer) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_xfer) begin
			byte_s1 <= byte_ch.data_byte;
		end
	end

	u2u_step #(
		.COUNT_BITS(COUNT_BITS)
	) u_step (
		.data_byte(byte_s1),
		.st(state_q),
		.count(count_q),
		.count_only(count_only_q),
		.max_units(max_units_q),
		.st_next(state_next),
		.count_next(count_next),
		.res(res)
	);

	// string state moves only when the decoded result enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			count_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				state_q <= state_next;
				count_q <= count_next;
				valid_s2 <= 1'b1;
			end else if (unit_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s2 <= res;
		end
	end

	assign unit_ch.valid = valid_s2;
	assign unit_ch.unit_valid = res_s2.unit_valid;
	assign unit_ch.code_unit = res_s2.code_unit;
	assign unit_ch.done_res = res_s2.done_res;
	assign unit_ch.status = res_s2.status;
	assign unit_ch.unit_count = res_s2.unit_count;

`ifndef NO_ASSERTIONS
	a_unit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.unit_valid |-> res_s2.status == STATUS_OK)
		else $error("code unit emitted with error status");

	a_discard_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status == STATUS_DISCARD |-> !res_s2.done_res && !res_s2.unit_valid)
		else $error("discarded byte produced a unit or end");

	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.done_res && res_s2.unit_valid |-> res_s2.code_unit == 16'd0)
		else $error("terminator unit is not zero");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(byte_s1))
		else $error("input register lost a byte while stalled");
`endif

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
	import u2u_pkg::*;

	localparam int CNT_W = 16;
	localparam int HOLD_LEN = 300;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	u2u_byte_if byte_ch ();
	u2u_unit_if unit_ch ();

	utf8_to_utf16_decoder #(.COUNT_BITS(CNT_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_ch(byte_ch),
		.unit_ch(unit_ch)
	);

	always #4 clk = ~clk;

	// decoder state as the testbench sees it
	logic mode_count_only;
	logic [15:0] unit_limit;
	logic [1:0] str_pend;
	logic [15:0] str_part;
	logic [CNT_W-1:0] str_units;
	logic str_skip;

	logic [7:0] bytes_to_send[$];
	u2u_result_t units_due[$];
	int mismatches = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic tx_pause = 1'b0;
	logic rx_hold = 1'b0;
	logic hold_go = 1'b0;
	logic byte_went = 1'b0;

	function automatic void clear_string();
		str_pend = '0;
		str_part = '0;
		str_units = '0;
		str_skip = 1'b0;
	endfunction

	function automatic void bump_units();
		if (str_units != {CNT_W{1'b1}})
			str_units = str_units + 1'b1;
	endfunction

	function automatic u2u_result_t decode_byte(logic [7:0] b);
		u2u_result_t r;
		logic writing;
		writing = !mode_count_only;
		r = '0;
		r.status = STATUS_OK;
		if (str_skip) begin
			r.status = STATUS_DISCARD;
			r.unit_count = str_units[15:0];
			if (b == TERM_BYTE)
				clear_string();
		end else if (writing && unit_limit == 0 && str_pend == 0 && str_units == 0) begin
			// zero limit: the first byte ends the string, terminator included
			r.status = STATUS_LIMIT;
			r.done_res = 1'b1;
			r.unit_count = '0;
			if (b != TERM_BYTE)
				str_skip = 1'b1;
		end else if (b == TERM_BYTE) begin
			r.done_res = 1'b1;
			if (str_pend != 0)
				r.status = STATUS_INVALID;
			else if (writing && str_units < unit_limit)
				r.unit_valid = 1'b1;
			r.unit_count = str_units[15:0];
			clear_string();
		end else if (str_pend != 0) begin
			if ((b & CONT_MASK) != CONT_CODE) begin
				r.status = STATUS_INVALID;
				r.done_res = 1'b1;
				str_skip = 1'b1;
			end else if (str_pend >= 2) begin
				str_part = str_part | {4'b0, b[5:0], 6'b0};
				str_pend = 2'd1;
			end else begin
				if (writing) begin
					r.unit_valid = 1'b1;
					r.code_unit = str_part | {10'b0, b[5:0]};
				end
				str_pend = 2'd0;
			end
			r.unit_count = str_units[15:0];
		end else if (writing && str_units >= unit_limit) begin
			r.status = STATUS_LIMIT;
			r.done_res = 1'b1;
			str_skip = 1'b1;
			r.unit_count = str_units[15:0];
		end else begin
			if ((b & ASCII_MASK) == 0) begin
				bump_units();
				if (writing) begin
					r.unit_valid = 1'b1;
					r.code_unit = {9'b0, b[6:0]};
				end
			end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
				str_part = {5'b0, b[4:0], 6'b0};
				str_pend = 2'd1;
				bump_units();
			end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
				str_part = {b[3:0], 12'b0};
				str_pend = 2'd2;
				bump_units();
			end else begin
				r.status = STATUS_INVALID;
				r.done_res = 1'b1;
				str_skip = 1'b1;
			end
			r.unit_count = str_units[15:0];
		end
		return r;
	endfunction

	// transfers on both channels, checked at the rising edge
	always @(posedge clk) begin
		u2u_result_t want;
		u2u_result_t got;
		if (!arst_n) begin
			byte_went = 1'b0;
		end else begin
			byte_went = byte_ch.valid && byte_ch.ready;
			if (byte_went)
				units_due.push_back(decode_byte(byte_ch.data_byte));
			if (unit_ch.valid && unit_ch.ready) begin
				got.unit_valid = unit_ch.unit_valid;
				got.code_unit = unit_ch.code_unit;
				got.done_res = unit_ch.done_res;
				got.status = u2u_status_t'(unit_ch.status);
				got.unit_count = unit_ch.unit_count;
				if (units_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: unexpected result valid=%0b unit=%h done=%0b st=%0d cnt=%0d",
							got.unit_valid, got.code_unit, got.done_res, got.status,
							got.unit_count);
				end else begin
					want = units_due.pop_front();
					if (got.unit_valid !== want.unit_valid || got.code_unit !== want.code_unit
							|| got.done_res !== want.done_res || got.status !== want.status
							|| got.unit_count !== want.unit_count) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("tb: mismatch exp valid=%0b unit=%h done=%0b st=%0d cnt=%0d",
								want.unit_valid, want.code_unit, want.done_res, want.status,
								want.unit_count);
							$display(", got valid=%0b unit=%h done=%0b st=%0d cnt=%0d",
								got.unit_valid, got.code_unit, got.done_res, got.status,
								got.unit_count);
						end
					end
				end
			end
		end
	end

	// sender and receiver, driven on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
		end else if (!byte_ch.valid || byte_went) begin
			if (bytes_to_send.size() != 0 && !tx_pause
					&& $urandom_range(99) >= tx_idle_pct) begin
				byte_ch.valid <= 1'b1;
				byte_ch.data_byte <= bytes_to_send.pop_front();
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
		unit_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// long receiver hold-off so the input side backs up
	initial begin
		wait (hold_go);
		rx_hold = 1'b1;
		repeat (HOLD_LEN) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#10ms;
		$display("tb: FAIL");
		$finish;
	end

	function automatic logic [7:0] cont_byte();
		return CONT_CODE | 8'($urandom_range(63));
	endfunction

	// one string with random content, mostly well formed; returns bytes queued
	function automatic int queue_string();
		int n_chars;
		int pick;
		int k;
		int j;
		int sent;
		sent = 0;
		n_chars = $urandom_range(8, 0);
		if ($urandom_range(99) < 8) begin
			for (k = 0; k < n_chars; k++)
				bytes_to_send.push_back(8'($urandom_range(255, 1)));
			sent = n_chars;
		end else begin
			for (k = 0; k < n_chars; k++) begin
				pick = $urandom_range(99);
				if (pick < 40) begin
					bytes_to_send.push_back(8'($urandom_range(127, 1)));
					sent += 1;
				end else if (pick < 66) begin
					bytes_to_send.push_back(8'($urandom_range(8'hdf, 8'hc0)));
					bytes_to_send.push_back(cont_byte());
					sent += 2;
				end else if (pick < 94) begin
					bytes_to_send.push_back(8'($urandom_range(8'hef, 8'he0)));
					bytes_to_send.push_back(cont_byte());
					bytes_to_send.push_back(cont_byte());
					sent += 3;
				end else if (pick < 96) begin
					// stray continuation
					bytes_to_send.push_back(cont_byte());
					sent += 1;
				end else if (pick < 98) begin
					// four-byte or longer lead
					bytes_to_send.push_back(8'($urandom_range(255, 8'hf0)));
					for (j = 0; j < 3; j++)
						bytes_to_send.push_back(cont_byte());
					sent += 4;
				end else begin
					// sequence cut short by a non-continuation or by the terminator
					bytes_to_send.push_back(8'($urandom_range(8'hef, 8'hc0)));
					sent += 1;
					if ($urandom_range(1))
						break;
					bytes_to_send.push_back(8'($urandom_range(127, 1)));
					sent += 1;
				end
			end
		end
		bytes_to_send.push_back(TERM_BYTE);
		return sent + 1;
	endfunction

	task automatic fill_random(int n);
		int left;
		left = n;
		while (left > 0)
			left -= queue_string();
	endtask

	task automatic settle();
		while (bytes_to_send.size() != 0 || byte_ch.valid || units_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		if (idx == CFG_COUNT_ONLY)
			mode_count_only = value[0];
		else
			unit_limit = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_setup();
		int pick;
		logic [15:0] lim;
		set_reg(CFG_COUNT_ONLY, ($urandom_range(3) == 0) ? 16'd1 : 16'd0);
		pick = $urandom_range(99);
		if (pick < 10)
			lim = 16'd0;
		else if (pick < 60)
			lim = 16'($urandom_range(6, 1));
		else if (pick < 75)
			lim = 16'hffff;
		else
			lim = 16'($urandom_range(16'hffff));
		set_reg(CFG_MAX_UNITS, lim);
	endtask

	initial begin
		int seg;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_COUNT_ONLY;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = '0;
		unit_ch.ready = 1'b0;
		mode_count_only = 1'b0;
		unit_limit = MAX_UNITS_RESET;
		clear_string();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: each sequence length, then the encoding errors
		tx_idle_pct = 35;
		rx_idle_pct = 72;
		bytes_to_send.push_back(8'h41); bytes_to_send.push_back(8'h7f);
		bytes_to_send.push_back(8'hc2); bytes_to_send.push_back(8'h80);
		bytes_to_send.push_back(8'hef); bytes_to_send.push_back(8'hbf);
		bytes_to_send.push_back(8'hbf); bytes_to_send.push_back(TERM_BYTE);
		bytes_to_send.push_back(8'h80); bytes_to_send.push_back(8'h41);
		bytes_to_send.push_back(TERM_BYTE);
		bytes_to_send.push_back(8'hff); bytes_to_send.push_back(TERM_BYTE);
		bytes_to_send.push_back(8'hc2); bytes_to_send.push_back(8'h41);
		bytes_to_send.push_back(TERM_BYTE);
		bytes_to_send.push_back(8'he0); bytes_to_send.push_back(8'h80);
		bytes_to_send.push_back(TERM_BYTE);
		settle();
		// stop at the limit
		set_reg(CFG_MAX_UNITS, 16'd2);
		bytes_to_send.push_back(8'h41); bytes_to_send.push_back(8'h42);
		bytes_to_send.push_back(8'h43); bytes_to_send.push_back(TERM_BYTE);
		settle();
		// zero limit, on a character and on a bare terminator
		set_reg(CFG_MAX_UNITS, 16'd0);
		bytes_to_send.push_back(8'h41); bytes_to_send.push_back(TERM_BYTE);
		bytes_to_send.push_back(TERM_BYTE);
		settle();

		for (seg = 0; seg < 4; seg++) begin
			random_setup();
			fill_random(160);
			if (seg == 2) begin
				while (bytes_to_send.size() > 100)
					@(negedge clk);
				tx_pause = 1'b1;
				while (byte_ch.valid || units_due.size() != 0)
					@(negedge clk);
				tx_pause = 1'b0;
			end
			settle();
		end

		tx_idle_pct = 72;
		rx_idle_pct = 35;
		for (seg = 0; seg < 4; seg++) begin
			random_setup();
			fill_random(160);
			settle();
		end

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_reg(CFG_COUNT_ONLY, 16'd0);
		set_reg(CFG_MAX_UNITS, 16'hffff);
		hold_go = 1'b1;
		fill_random(250);
		settle();
		for (seg = 0; seg < 2; seg++) begin
			random_setup();
			fill_random(120);
			settle();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
